@@ hw/rtl/adrc_pkg.sv @@
package adrc_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_INV_RATIO = 2'd1;
  localparam logic [1:0] REG_ATTACK    = 2'd2;
  localparam logic [1:0] REG_RELEASE   = 2'd3;

  // register reset values
  localparam logic [15:0] THRESHOLD_RST = 16'hEC00;  // -20 dB in Q8.8
  localparam logic [16:0] INV_RATIO_RST = 17'd16384;
  localparam logic [15:0] ATTACK_RST    = 16'd65400;
  localparam logic [15:0] RELEASE_RST   = 16'd65522;

  // fixed-point constants
  localparam logic signed [15:0] DB_FLOOR   = -16'sd25600;
  localparam logic [16:0]        UNITY_GAIN = 17'd65536;
  localparam logic [23:0]        DB_PER_LOG2 = 24'd394566;
  localparam logic [23:0]        LOG2_PER_DB = 24'd2786635;

  // log2 of a Q1.30 mantissa in [1,2) as Q0.16, by repeated squaring
  function automatic logic [15:0] adrc_log2_sq(input logic [63:0] m_in);
    logic [63:0] m;
    logic [15:0] r;
    m = m_in;
    r = '0;
    for (int k = 1; k <= 16; k++) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        r[16-k] = 1'b1;
      end
    end
    return r;
  endfunction

  // log table entry i for a table of 2^ltb entries
  function automatic logic [15:0] adrc_log_entry(input int i, input int ltb);
    logic [63:0] m;
    m = (64'(1) << 30) + (64'(i) << (30 - ltb));
    return adrc_log2_sq(m);
  endfunction

  // exp table entry i: least mantissa whose log reaches i/2^ltb
  function automatic logic [16:0] adrc_exp_entry(input int i, input int ltb);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] target;
    lo = 64'd65536;
    hi = 64'd131071;
    mid = '0;
    target = 64'(i) << (16 - ltb);
    for (int k = 0; k < 18; k++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if ({48'd0, adrc_log2_sq(mid << 14)} >= target) begin
          hi = mid;
        end else begin
          lo = mid + 64'd1;
        end
      end
    end
    return lo[16:0];
  endfunction

endpackage

@@ hw/rtl/adrc_mac.sv @@
module adrc_mac import adrc_pkg::*; #(
  parameter int AW = 25,
  parameter int BW = 24
) (
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  input  logic signed [AW+BW-1:0] c_i,
  output logic signed [AW+BW-1:0] p_o
);

  logic signed [AW+BW-1:0] prod;

  // signed multiply with addend
  always_comb begin
    prod = a_i * b_i;
    p_o  = prod + c_i;
  end

endmodule

@@ hw/rtl/audio_dynamic_range_compressor.sv @@
// Feedforward dynamic range compressor, one audio word per transaction.
// Input channel: in_valid_i / in_stall_o with in_sample_i (signed Q1.x).
// Output channel: out_valid_o / out_stall_i with out_sample_o and
// applied_gain_o (Q1.16, 65536 is unity).
// A word is taken when valid is high and stall is low. One shared
// multiply-add unit is stepped by a small sequencer through envelope
// smoothing, log conversion, compression, exp conversion, gain smoothing
// and the output multiply. Each word passes E0 and E1, then a normalise state
// that shifts once per leading zero of the new envelope below its top bit (0 to
// SAMPLE_BITS-1), then LOG, CMP, EXP, GR, G0, G1 and OUT; a zero envelope
// skips the normalise and log steps. The next word can be accepted once the
// result is in the output register.
// in_stall_o is high while a word is in work.
// The result sits in an output register; the next word is accepted while
// it waits. If the receiver still stalls when the next result is ready the
// sequencer holds until the register is free.
// Reset (rst_ni low, asynchronous) clears the envelope to zero, the gain
// to unity and loads the register defaults. Configuration writes
// (cfg_we_i, cfg_addr_i, cfg_wdata_i) take effect at once; write only
// while the block is idle.
module audio_dynamic_range_compressor import adrc_pkg::*; #(
  parameter int SAMPLE_BITS    = 24,
  parameter int LOG_TABLE_BITS = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] in_sample_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [SAMPLE_BITS-1:0] out_sample_o,
  output logic [16:0]            applied_gain_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_addr_i,
  input  logic [16:0]            cfg_wdata_i
);

  localparam int S   = SAMPLE_BITS;
  localparam int LTB = LOG_TABLE_BITS;
  localparam int TAB = 1 << LTB;
  localparam int MAW = (S + 1 > 24) ? S + 1 : 24;
  localparam int BW  = 24;
  localparam int PW  = MAW + BW;
  localparam int YW  = PW - 16;
  localparam int PBW = $clog2(S);

  // sequencer states
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_E0   = 4'd1;
  localparam logic [3:0] ST_E1   = 4'd2;
  localparam logic [3:0] ST_NORM = 4'd3;
  localparam logic [3:0] ST_LOG  = 4'd4;
  localparam logic [3:0] ST_CMP  = 4'd5;
  localparam logic [3:0] ST_EXP  = 4'd6;
  localparam logic [3:0] ST_GR   = 4'd7;
  localparam logic [3:0] ST_G0   = 4'd8;
  localparam logic [3:0] ST_G1   = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  // constant tables
  logic [15:0] log_tab [TAB];
  logic [16:0] exp_tab [TAB];

  for (genvar g = 0; g < TAB; g++) begin : g_rom
    localparam logic [15:0] LOG_V = adrc_log_entry(g, LTB);
    localparam logic [16:0] EXP_V = adrc_exp_entry(g, LTB);
    assign log_tab[g] = LOG_V;
    assign exp_tab[g] = EXP_V;
  end

  logic [3:0]             state_q, state_d;
  logic [S-1:0]           env_q, env_d;
  logic [16:0]            gain_q, gain_d;
  logic [S-1:0]           x_q, x_d;
  logic [S-1:0]           mag_q, mag_d;
  logic [15:0]            coef_q, coef_d;
  logic signed [PW-1:0]   acc_q, acc_d;
  logic [S-1:0]           norm_q, norm_d;
  logic [PBW-1:0]         pos_q, pos_d;
  logic signed [15:0]     db_q, db_d;
  logic signed [17:0]     red_q, red_d;
  logic signed [23:0]     t_q, t_d;
  logic [16:0]            gr_q, gr_d;
  logic [S-1:0]           out_sample_q, out_sample_d;
  logic [16:0]            out_gain_q, out_gain_d;
  logic                   out_valid_q, out_valid_d;
  logic [15:0]            thr_q;
  logic [16:0]            inv_q;
  logic [15:0]            atk_q;
  logic [15:0]            rel_q;

  logic signed [MAW-1:0]  mul_a;
  logic signed [BW-1:0]   mul_b;
  logic signed [PW-1:0]   mul_c;
  logic signed [PW-1:0]   mul_p;
  logic signed [PW-1:0]   sum;
  logic [16:0]            coef_inv;
  logic [16:0]            ir_sat;
  logic [7:0]             hi8;
  logic signed [22:0]     lval;
  logic signed [17:0]     dbw;
  logic signed [16:0]     diff;
  logic signed [17:0]     quo;
  logic [8:0]             shift;
  logic [16:0]            e_val;
  logic signed [YW-1:0]   yw;
  logic signed [YW-1:0]   ymax;
  logic signed [YW-1:0]   ymin;
  logic                   accept;
  logic                   out_free;

  // shared multiply-add unit
  adrc_mac #(
    .AW (MAW),
    .BW (BW)
  ) u_mac (
    .a_i (mul_a),
    .b_i (mul_b),
    .c_i (mul_c),
    .p_o (mul_p)
  );

  assign in_stall_o     = (state_q != ST_IDLE);
  assign accept         = in_valid_i && !in_stall_o;
  assign out_free       = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_sample_o   = out_sample_q;
  assign applied_gain_o = out_gain_q;

  assign coef_inv = 17'd65536 - {1'b0, coef_q};
  assign ir_sat   = (inv_q > UNITY_GAIN) ? UNITY_GAIN : inv_q;
  assign hi8      = {{(8 - PBW){1'b0}}, pos_q} - 8'(S - 1);
  assign lval     = {hi8[6:0], log_tab[norm_q[S-2 -: LTB]]};
  assign diff     = {db_q[15], db_q} - {thr_q[15], thr_q};
  assign shift    = 9'd0 - {t_q[23], t_q[23:16]};
  assign e_val    = exp_tab[t_q[15 -: LTB]];
  assign sum      = acc_q + mul_p;
  assign ymax     = {{(YW - S + 1){1'b0}}, {(S - 1){1'b1}}};
  assign ymin     = {{(YW - S + 1){1'b1}}, {(S - 1){1'b0}}};
  assign dbw      = mul_p[24 +: 18];
  assign quo      = mul_p[16 +: 18];
  assign yw       = mul_p[PW-1:16];

  // sequencer and datapath steps
  always_comb begin
    state_d      = state_q;
    env_d        = env_q;
    gain_d       = gain_q;
    x_d          = x_q;
    mag_d        = mag_q;
    coef_d       = coef_q;
    acc_d        = acc_q;
    norm_d       = norm_q;
    pos_d        = pos_q;
    db_d         = db_q;
    red_d        = red_q;
    t_d          = t_q;
    gr_d         = gr_q;
    out_sample_d = out_sample_q;
    out_gain_d   = out_gain_q;
    out_valid_d  = out_valid_q && out_stall_i;
    mul_a        = '0;
    mul_b        = '0;
    mul_c        = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          x_d     = in_sample_i;
          mag_d   = in_sample_i[S-1] ? (~in_sample_i + 1'b1) : in_sample_i;
          state_d = ST_E0;
        end
      end
      ST_E0: begin
        coef_d  = (mag_q > env_q) ? atk_q : rel_q;
        mul_a   = {{(MAW - S){1'b0}}, env_q};
        mul_b   = {8'd0, coef_d};
        acc_d   = mul_p;
        state_d = ST_E1;
      end
      ST_E1: begin
        mul_a  = {{(MAW - S){1'b0}}, mag_q};
        mul_b  = {7'd0, coef_inv};
        mul_c  = PW'(32768);
        env_d  = sum[16 +: S];
        norm_d = sum[16 +: S];
        pos_d  = PBW'(S - 1);
        if (sum[16 +: S] == '0) begin
          db_d    = DB_FLOOR;
          state_d = ST_CMP;
        end else begin
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        if (norm_q[S-1]) begin
          state_d = ST_LOG;
        end else begin
          norm_d = {norm_q[S-2:0], 1'b0};
          pos_d  = pos_q - 1'b1;
        end
      end
      ST_LOG: begin
        mul_a   = {{(MAW - 23){lval[22]}}, lval};
        mul_b   = DB_PER_LOG2;
        mul_c   = PW'(24'h800000);
        db_d    = (dbw < 18'(DB_FLOOR)) ? DB_FLOOR : dbw[15:0];
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if ($signed(db_q) > $signed(thr_q)) begin
          mul_a = {{(MAW - 17){diff[16]}}, diff};
          mul_b = {7'd0, ir_sat};
          red_d = {{2{thr_q[15]}}, thr_q} + quo - {{2{db_q[15]}}, db_q};
        end else begin
          red_d = '0;
        end
        state_d = ST_EXP;
      end
      ST_EXP: begin
        mul_a   = {{(MAW - 18){red_q[17]}}, red_q};
        mul_b   = LOG2_PER_DB;
        t_d     = mul_p[16 +: 24];
        state_d = ST_GR;
      end
      ST_GR: begin
        gr_d    = (shift >= 9'd17) ? 17'd0 : (e_val >> shift);
        state_d = ST_G0;
      end
      ST_G0: begin
        coef_d  = (gr_q < gain_q) ? atk_q : rel_q;
        mul_a   = {{(MAW - 17){1'b0}}, gain_q};
        mul_b   = {8'd0, coef_d};
        acc_d   = mul_p;
        state_d = ST_G1;
      end
      ST_G1: begin
        mul_a   = {{(MAW - 17){1'b0}}, gr_q};
        mul_b   = {7'd0, coef_inv};
        mul_c   = PW'(32768);
        gain_d  = sum[16 +: 17];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        mul_a = {{(MAW - S){x_q[S-1]}}, x_q};
        mul_b = {7'd0, gain_q};
        mul_c = PW'(32768);
        if (out_free) begin
          if (yw > ymax) begin
            out_sample_d = ymax[S-1:0];
          end else if (yw < ymin) begin
            out_sample_d = ymin[S-1:0];
          end else begin
            out_sample_d = yw[S-1:0];
          end
          out_gain_d  = gain_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      env_q       <= '0;
      gain_q      <= UNITY_GAIN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      env_q       <= env_d;
      gain_q      <= gain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    x_q          <= x_d;
    mag_q        <= mag_d;
    coef_q       <= coef_d;
    acc_q        <= acc_d;
    norm_q       <= norm_d;
    pos_q        <= pos_d;
    db_q         <= db_d;
    red_q        <= red_d;
    t_q          <= t_d;
    gr_q         <= gr_d;
    out_sample_q <= out_sample_d;
    out_gain_q   <= out_gain_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RST;
      inv_q <= INV_RATIO_RST;
      atk_q <= ATTACK_RST;
      rel_q <= RELEASE_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_THRESHOLD: thr_q <= cfg_wdata_i[15:0];
        REG_INV_RATIO: inv_q <= cfg_wdata_i;
        REG_ATTACK:    atk_q <= cfg_wdata_i[15:0];
        REG_RELEASE:   rel_q <= cfg_wdata_i[15:0];
        default: begin
        end
      endcase
    end
  end

endmodule
